>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants shared by the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int VIDEO_CELLS_DEF = 16384;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 14;
    localparam int POS_W   = 12;
    localparam int CUR_W   = 11;
    localparam int WIDE_W  = 15;

    localparam logic [ROW_W-1:0] ROW_MAX    = 5'd31;
    localparam logic [7:0]       ATTR_RESET = 8'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // command operations
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PUT  = 2'd1;
    localparam logic [1:0] OP_TAB  = 2'd2;
    localparam logic [1:0] OP_LF   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] cell_address;
        logic [15:0]       cell_value;
        logic [ADDR_W-1:0] display_start;
        logic [CUR_W-1:0]  cursor_position;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic       eot;
    } cmd_t;

endpackage

>>> sv/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts characters and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output tcw_pkg::cmd_t     q_cmd
);

    always_comb begin
        q_cmd.ch  = s_data.char_code;
        q_cmd.eot = s_data.end_of_text;
        unique case (s_data.char_code) inside
            tcw_pkg::CH_NUL: begin
                q_cmd.op = tcw_pkg::OP_PUT;
                q_cmd.ch = tcw_pkg::CH_SPACE;
            end
            tcw_pkg::CH_TAB: begin
                q_cmd.op = tcw_pkg::OP_TAB;
                q_cmd.ch = tcw_pkg::CH_SPACE;
            end
            tcw_pkg::CH_LF: begin
                q_cmd.op = tcw_pkg::OP_LF;
            end
            tcw_pkg::CH_BEL, tcw_pkg::CH_BS, tcw_pkg::CH_VT, tcw_pkg::CH_FF,
            tcw_pkg::CH_CR, tcw_pkg::CH_ESC, tcw_pkg::CH_DEL: begin
                q_cmd.op = tcw_pkg::OP_NONE;
            end
            default: begin
                q_cmd.op = tcw_pkg::OP_PUT;
            end
        endcase
    end

    assign s_ready = !q_full;
    // ignored codes without end of text produce nothing and are dropped here
    assign q_push  = s_valid && !q_full && !(q_cmd.op == tcw_pkg::OP_NONE && !q_cmd.eot);

endmodule

>>> sv/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcw_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcw_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tcw_pkg::cmd_t head_cmd
);

    tcw_pkg::cmd_t                   mem_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [tcw_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [tcw_pkg::QUEUE_CW-1:0]    count_reg;
    logic [tcw_pkg::QUEUE_CW-1:0]    count_next;

    assign full       = count_reg == tcw_pkg::QUEUE_CW'(tcw_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && head_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop && head_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands: keeps the cursor and display start, emits one result
// per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int VIDEO_CELLS = tcw_pkg::VIDEO_CELLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         text_attribute,
    input  logic               head_valid,
    input  tcw_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::out_item_t m_data
);

    localparam logic [1:0] ST_BODY   = 2'd0;
    localparam logic [1:0] ST_EOT    = 2'd1;
    localparam logic [1:0] ST_CURSOR = 2'd2;

    localparam logic [tcw_pkg::POS_W-1:0]  COLS_P    = tcw_pkg::POS_W'(COLUMNS);
    localparam logic [tcw_pkg::POS_W-1:0]  ROW_LIMIT = tcw_pkg::POS_W'((ROWS - 1) * COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW  = tcw_pkg::ROW_W'(ROWS - 1);
    localparam logic [tcw_pkg::COL_W:0]    COLS_C    = (tcw_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [tcw_pkg::WIDE_W-1:0] VC        = tcw_pkg::WIDE_W'(VIDEO_CELLS);
    localparam logic [tcw_pkg::WIDE_W-1:0] COLS_W    = tcw_pkg::WIDE_W'(COLUMNS);

    logic [1:0]                  state_reg, state_next, state_eff;
    logic [1:0]                  step_reg, step_next;
    logic [tcw_pkg::COL_W-1:0]   column_reg, column_next;
    logic [tcw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tcw_pkg::ADDR_W-1:0]  start_reg, start_next;
    logic                        m_valid_reg;
    tcw_pkg::out_item_t          m_data_reg, m_data_next;

    logic                        fire;
    logic [tcw_pkg::POS_W-1:0]   pos, pos_lf;
    logic [tcw_pkg::WIDE_W-1:0]  pos_w, pos_m, sum_w, addr_w, start_w;
    logic [tcw_pkg::COL_W:0]     col_inc;
    logic                        col_wrap;
    logic [tcw_pkg::ROW_W-1:0]   row_inc;
    logic                        body_final;

    assign fire      = head_valid && (!m_valid_reg || m_ready);
    assign state_eff = (state_reg == ST_BODY && head_cmd.op == tcw_pkg::OP_NONE)
                       ? ST_EOT : state_reg;

    assign pos     = tcw_pkg::POS_W'(row_reg) * COLS_P + tcw_pkg::POS_W'(column_reg);
    assign row_inc = (row_reg == tcw_pkg::ROW_MAX) ? row_reg : row_reg + 1'b1;
    assign pos_lf  = tcw_pkg::POS_W'(row_inc) * COLS_P;

    // cell address wraps in video memory
    assign pos_w  = tcw_pkg::WIDE_W'(pos);
    assign pos_m  = (pos_w >= VC) ? pos_w - VC : pos_w;
    assign sum_w  = tcw_pkg::WIDE_W'(start_reg) + pos_m;
    assign addr_w = (sum_w >= VC) ? sum_w - VC : sum_w;

    assign start_w = tcw_pkg::WIDE_W'(start_reg) + COLS_W;

    assign col_inc  = {1'b0, column_reg} + 1'b1;
    assign col_wrap = col_inc >= COLS_C;

    assign body_final = (head_cmd.op != tcw_pkg::OP_TAB) || (step_reg == 2'd3);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        column_next = column_reg;
        row_next    = row_reg;
        start_next  = start_reg;
        pop         = 1'b0;
        m_data_next = '0;
        unique case (state_eff)
            ST_BODY: begin
                if (head_cmd.op == tcw_pkg::OP_LF) begin
                    column_next                 = '0;
                    row_next                    = row_inc;
                    m_data_next.kind            = tcw_pkg::KIND_CURSOR;
                    m_data_next.cursor_position = pos_lf[tcw_pkg::CUR_W-1:0];
                end else begin
                    m_data_next.kind         = tcw_pkg::KIND_CELL;
                    m_data_next.cell_address = addr_w[tcw_pkg::ADDR_W-1:0];
                    m_data_next.cell_value   = {text_attribute, head_cmd.ch};
                    column_next = col_wrap ? '0 : col_inc[tcw_pkg::COL_W-1:0];
                    row_next    = col_wrap ? row_inc : row_reg;
                end
                m_data_next.last = body_final && !head_cmd.eot;
                if (body_final) begin
                    step_next = '0;
                    if (head_cmd.eot) begin
                        state_next = ST_EOT;
                    end else begin
                        pop = 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EOT: begin
                if (pos > ROW_LIMIT) begin
                    start_next = (start_w >= VC) ? start_w[tcw_pkg::ADDR_W-1:0] -
                                 VC[tcw_pkg::ADDR_W-1:0] : start_w[tcw_pkg::ADDR_W-1:0];
                    row_next   = LAST_ROW;
                    state_next = ST_CURSOR;
                    m_data_next.kind          = tcw_pkg::KIND_START;
                    m_data_next.display_start = start_next;
                end else begin
                    state_next = ST_BODY;
                    pop        = 1'b1;
                    m_data_next.kind            = tcw_pkg::KIND_CURSOR;
                    m_data_next.cursor_position = pos[tcw_pkg::CUR_W-1:0];
                    m_data_next.last            = 1'b1;
                end
            end
            ST_CURSOR: begin
                state_next = ST_BODY;
                pop        = 1'b1;
                m_data_next.kind            = tcw_pkg::KIND_CURSOR;
                m_data_next.cursor_position = pos[tcw_pkg::CUR_W-1:0];
                m_data_next.last            = 1'b1;
            end
            default: begin
                state_next = ST_BODY;
            end
        endcase
        if (!fire) begin
            pop = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_BODY;
            step_reg    <= '0;
            column_reg  <= '0;
            row_reg     <= '0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg  <= state_next;
                step_reg   <= step_next;
                column_reg <= column_next;
                row_reg    <= row_next;
                start_reg  <= start_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text console character writer: front decoder, command queue, back executor.
// ----------------------------------------------------------------------------
// The first result of an item reaches m_data through the queue write, then the
// output register.
// Throughput: one item per cycle enters while the queue has room; the back
// emits one result per cycle while m_ready does not stall it, up to six results
// per item (ignored codes without end of text are dropped up front).
// Reset: cursor, display start and queue clear; attribute returns to 7.
module text_console_char_writer_top #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int VIDEO_CELLS = tcw_pkg::VIDEO_CELLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::out_item_t m_data
);

    logic [7:0]    text_attribute_reg;
    logic          q_full, q_push, q_pop, head_valid;
    tcw_pkg::cmd_t q_cmd, head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attribute_reg <= tcw_pkg::ATTR_RESET;
        end else if (cfg_wr_en) begin
            text_attribute_reg <= cfg_wr_data;
        end
    end

    tcw_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    tcw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tcw_back #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .VIDEO_CELLS (VIDEO_CELLS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .text_attribute (text_attribute_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

`ifndef SYNTHESIS
    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == tcw_pkg::KIND_START |-> !m_data.last)
        else $error("display start update marked last");

    a_cursor_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == tcw_pkg::KIND_CURSOR |->
            m_data.cell_address == '0 && m_data.cell_value == '0 &&
            m_data.display_start == '0)
        else $error("cursor update carries cell fields");

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> head_valid && (!m_valid || m_ready))
        else $error("queue pop without a command or output space");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_full)
        else $error("input stalled with room in the queue");
`endif

endmodule
